// ===== hdl/snap_ring_node_receiver_defines.svh =====
// assertion macros shared by the checker
`ifndef SNAP_RING_NODE_RECEIVER_DEFINES_SVH
`define SNAP_RING_NODE_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SNRR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define SNRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/snrr_pkg.sv =====
`timescale 1ns / 1ps
package snrr_pkg;

	localparam int PAYLOAD_MAX_DEF = 15;
	localparam int FLUSH_COUNT_DEF = 8;
	localparam int RESULT_LIMIT    = 8;
	localparam int QUEUE_DEPTH     = 4;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;

	localparam logic [7:0] SYNC_BYTE   = 8'h54;
	localparam logic [7:0] HDB2_ACK    = 8'h52;
	localparam logic [7:0] HDB2_NAK    = 8'h53;
	localparam logic [7:0] HDB1_REPLY  = 8'h30;
	localparam logic [5:0] HDB2_TAG    = 6'b010100;
	localparam logic [3:0] HDB1_TAG    = 4'b0011;
	localparam logic [1:0] ACK_REQUEST = 2'b01;

	// maxim crc-8, reflected poly 0x8c, one byte per call
	localparam logic [7:0] CRC_BITS [8] = '{
		8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
	};

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_SYNC      = 4'd1,
		PH_HDB2      = 4'd2,
		PH_HDB1      = 4'd3,
		PH_DAB       = 4'd4,
		PH_DATA      = 4'd5,
		PH_CRC       = 4'd6,
		PH_DAB_PASS  = 4'd7,
		PH_DATA_PASS = 4'd8
	} rx_phase_t;

	typedef enum logic [2:0] {
		JOB_STATUS  = 3'd0,
		JOB_PAYLOAD = 3'd1,
		JOB_FWD1    = 3'd2,
		JOB_FWD4    = 3'd3,
		JOB_REPLY   = 3'd4,
		JOB_FLUSH   = 3'd5
	} job_kind_t;

	typedef enum logic [0:0] {
		OP_BYTE    = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic       packet_ready;
		logic [7:0] reply_address;
		logic       forwarding;
		logic       header_error;
	} status_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] byte_a;   // received byte, or reply destination
		logic [7:0] byte_b;   // saved hdb2, or reply hdb2
		logic [7:0] byte_c;   // saved hdb1
		logic [3:0] pidx;
		status_t    status;
	} job_t;

	function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] v;
		logic [7:0] r;
		v = b ^ acc;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			if (v[k]) begin
				r = r ^ CRC_BITS[k];
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/snrr_front.sv =====
`timescale 1ns / 1ps
// receive state machine: one input transfer per cycle while the job queue is not full, one job out per transfer
module snrr_front #(
	parameter int PAYLOAD_MAX = snrr_pkg::PAYLOAD_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_op,
	input  logic [7:0]         in_byte,
	input  logic [7:0]         dev_addr,
	input  logic               queue_full,
	output logic               push,
	output snrr_pkg::job_t     job
);

	localparam logic [3:0] LEN_CAP = 4'(PAYLOAD_MAX);

	snrr_pkg::rx_phase_t phase_q, phase_d;
	logic [7:0] hdb2_q, hdb2_d;
	logic [7:0] hdb1_q, hdb1_d;
	logic [4:0] len_q, len_d;
	logic [7:0] src_q, src_d;
	logic [3:0] idx_q, idx_d;
	logic [7:0] crc_q, crc_d;
	logic       ack_q, ack_d;
	logic       lock_q, lock_d;
	logic       pass_q, pass_d;
	logic       abort_q, abort_d;
	logic [7:0] last_src_q, last_src_d;
	logic       herr;
	logic [4:0] len_dec;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;
	assign len_dec  = (len_q != 5'd0) ? len_q - 5'd1 : 5'd0;

	always_comb begin
		phase_d    = phase_q;
		hdb2_d     = hdb2_q;
		hdb1_d     = hdb1_q;
		len_d      = len_q;
		src_d      = src_q;
		idx_d      = idx_q;
		crc_d      = crc_q;
		ack_d      = ack_q;
		lock_d     = lock_q;
		pass_d     = pass_q;
		abort_d    = abort_q;
		last_src_d = last_src_q;
		herr       = 1'b0;
		job.kind   = snrr_pkg::JOB_STATUS;
		job.byte_a = in_byte;
		job.byte_b = hdb2_q;
		job.byte_c = hdb1_q;
		job.pidx   = idx_q;
		if (in_op == snrr_pkg::OP_RELEASE) begin
			lock_d = 1'b0;
		end else begin
			case (phase_q)
				snrr_pkg::PH_IDLE: begin
					if (in_byte == snrr_pkg::SYNC_BYTE) begin
						phase_d = snrr_pkg::PH_SYNC;
						abort_d = 1'b0;
					end
				end
				snrr_pkg::PH_SYNC: begin
					hdb2_d = in_byte;
					if (in_byte[7:2] != snrr_pkg::HDB2_TAG) begin
						herr = 1'b1;
					end else begin
						ack_d   = (in_byte[1:0] == snrr_pkg::ACK_REQUEST);
						crc_d   = snrr_pkg::crc8_feed(8'h00, in_byte);
						phase_d = snrr_pkg::PH_HDB2;
					end
				end
				snrr_pkg::PH_HDB2: begin
					hdb1_d = in_byte;
					if (in_byte[7:4] != snrr_pkg::HDB1_TAG) begin
						herr = 1'b1;
					end else begin
						len_d   = {1'b0, (in_byte[3:0] > LEN_CAP) ? LEN_CAP : in_byte[3:0]};
						crc_d   = snrr_pkg::crc8_feed(crc_q, in_byte);
						phase_d = snrr_pkg::PH_HDB1;
					end
				end
				snrr_pkg::PH_HDB1: begin
					if (in_byte != dev_addr) begin
						job.kind = snrr_pkg::JOB_FWD4;
						phase_d  = snrr_pkg::PH_DAB_PASS;
						ack_d    = 1'b0;
						pass_d   = 1'b1;
					end else begin
						crc_d   = snrr_pkg::crc8_feed(crc_q, in_byte);
						phase_d = snrr_pkg::PH_DAB;
					end
				end
				snrr_pkg::PH_DAB: begin
					if (lock_q) begin
						// busy: nak straight back to the incoming source
						job.kind   = snrr_pkg::JOB_REPLY;
						job.byte_b = snrr_pkg::HDB2_NAK;
						ack_d      = 1'b0;
						abort_d    = 1'b1;
						phase_d    = snrr_pkg::PH_IDLE;
					end else begin
						src_d   = in_byte;
						idx_d   = 4'd0;
						crc_d   = snrr_pkg::crc8_feed(crc_q, in_byte);
						phase_d = (len_q == 5'd0) ? snrr_pkg::PH_CRC : snrr_pkg::PH_DATA;
					end
				end
				snrr_pkg::PH_DATA: begin
					job.kind = snrr_pkg::JOB_PAYLOAD;
					idx_d    = idx_q + 4'd1;
					crc_d    = snrr_pkg::crc8_feed(crc_q, in_byte);
					len_d    = len_dec;
					if (len_dec == 5'd0) begin
						phase_d = snrr_pkg::PH_CRC;
					end
				end
				snrr_pkg::PH_CRC: begin
					job.byte_a = src_q;
					job.byte_b = snrr_pkg::HDB2_NAK;
					if (in_byte == crc_q) begin
						job.byte_b = snrr_pkg::HDB2_ACK;
						lock_d     = 1'b1;
						last_src_d = src_q;
					end
					if (ack_q) begin
						job.kind = snrr_pkg::JOB_REPLY;
						ack_d    = 1'b0;
					end
					phase_d = snrr_pkg::PH_IDLE;
				end
				snrr_pkg::PH_DAB_PASS: begin
					job.kind = snrr_pkg::JOB_FWD1;
					len_d    = len_q + 5'd1;
					phase_d  = snrr_pkg::PH_DATA_PASS;
				end
				snrr_pkg::PH_DATA_PASS: begin
					job.kind = snrr_pkg::JOB_FWD1;
					if (len_q > 5'd1) begin
						len_d = len_q - 5'd1;
					end else begin
						phase_d = snrr_pkg::PH_IDLE;
						pass_d  = 1'b0;
					end
				end
				default: begin
					herr = 1'b1;
				end
			endcase
			if (herr) begin
				// bad header: flush unless this packet was already aborted
				job.kind = abort_q ? snrr_pkg::JOB_STATUS : snrr_pkg::JOB_FLUSH;
				ack_d    = 1'b0;
				lock_d   = 1'b0;
				pass_d   = 1'b0;
				phase_d  = snrr_pkg::PH_IDLE;
			end
		end
		job.status.packet_ready  = lock_d;
		job.status.reply_address = last_src_d;
		job.status.forwarding    = pass_d;
		job.status.header_error  = herr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= snrr_pkg::PH_IDLE;
			hdb2_q     <= '0;
			hdb1_q     <= '0;
			len_q      <= '0;
			src_q      <= '0;
			idx_q      <= '0;
			crc_q      <= '0;
			ack_q      <= 1'b0;
			lock_q     <= 1'b0;
			pass_q     <= 1'b0;
			abort_q    <= 1'b0;
			last_src_q <= '0;
		end else if (push) begin
			phase_q    <= phase_d;
			hdb2_q     <= hdb2_d;
			hdb1_q     <= hdb1_d;
			len_q      <= len_d;
			src_q      <= src_d;
			idx_q      <= idx_d;
			crc_q      <= crc_d;
			ack_q      <= ack_d;
			lock_q     <= lock_d;
			pass_q     <= pass_d;
			abort_q    <= abort_d;
			last_src_q <= last_src_d;
		end
	end

endmodule

// ===== hdl/snrr_fifo.sv =====
`timescale 1ns / 1ps
// short job queue between front and back
module snrr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  snrr_pkg::job_t wr_data,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output snrr_pkg::job_t rd_data
);

	localparam int DEPTH = snrr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	snrr_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/snrr_back.sv =====
`timescale 1ns / 1ps
// expands one job into its run of output transfers, one per cycle while out_ready does not stall it
module snrr_back #(
	parameter int FLUSH_COUNT = snrr_pkg::FLUSH_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	input  snrr_pkg::job_t                   job_head,
	output logic                             pop,
	input  logic [7:0]                       dev_addr,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [snrr_pkg::M_TDATA_W-1:0]   out_data,
	output logic                             out_last
);

	localparam int FLUSH_N = (FLUSH_COUNT > snrr_pkg::RESULT_LIMIT) ?
		snrr_pkg::RESULT_LIMIT : FLUSH_COUNT;
	localparam logic [2:0] FLUSH_LAST = 3'(FLUSH_N - 1);
	localparam int PAD_W = snrr_pkg::M_TDATA_W - 33;

	snrr_pkg::job_t job_q;
	logic           busy_q;
	logic [2:0]     step_q;
	logic [7:0]     crc_q;
	logic           o_valid_q;
	logic [snrr_pkg::M_TDATA_W-1:0] o_data_q;
	logic           o_last_q;

	logic       can_emit;
	logic       last_step;
	logic [2:0] step_last;
	logic       txv;
	logic [7:0] txb;
	logic       pv;

	assign can_emit  = busy_q && (!o_valid_q || out_ready);
	assign last_step = (step_q == step_last);
	assign pop       = job_valid && (!busy_q || (can_emit && last_step));

	always_comb begin
		step_last = 3'd0;
		txv       = 1'b0;
		txb       = 8'h00;
		pv        = 1'b0;
		case (job_q.kind)
			snrr_pkg::JOB_STATUS: begin
				step_last = 3'd0;
			end
			snrr_pkg::JOB_PAYLOAD: begin
				pv = 1'b1;
			end
			snrr_pkg::JOB_FWD1: begin
				txv = 1'b1;
				txb = job_q.byte_a;
			end
			snrr_pkg::JOB_FWD4: begin
				step_last = 3'd3;
				txv       = 1'b1;
				case (step_q)
					3'd0:    txb = snrr_pkg::SYNC_BYTE;
					3'd1:    txb = job_q.byte_b;
					3'd2:    txb = job_q.byte_c;
					default: txb = job_q.byte_a;
				endcase
			end
			snrr_pkg::JOB_REPLY: begin
				step_last = 3'd5;
				txv       = 1'b1;
				case (step_q)
					3'd0:    txb = snrr_pkg::SYNC_BYTE;
					3'd1:    txb = job_q.byte_b;
					3'd2:    txb = snrr_pkg::HDB1_REPLY;
					3'd3:    txb = job_q.byte_a;
					3'd4:    txb = dev_addr;
					default: txb = crc_q;
				endcase
			end
			snrr_pkg::JOB_FLUSH: begin
				step_last = FLUSH_LAST;
				txv       = 1'b1;
			end
			default: begin
				step_last = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (can_emit) begin
				o_valid_q <= 1'b1;
				step_q    <= last_step ? 3'd0 : step_q + 3'd1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (can_emit && last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_head;
		end
		if (can_emit) begin
			// reply crc runs over hdb2, hdb1, destination and source
			if (step_q == 3'd0) begin
				crc_q <= 8'h00;
			end else if (step_q < 3'd5) begin
				crc_q <= snrr_pkg::crc8_feed(crc_q, txb);
			end
			o_last_q <= last_step;
			o_data_q <= {
				{PAD_W{1'b0}},
				job_q.status.header_error,
				job_q.status.forwarding,
				job_q.status.reply_address,
				job_q.status.packet_ready,
				pv ? job_q.byte_a : 8'h00,
				pv ? job_q.pidx : 4'h0,
				pv,
				txb,
				txv
			};
		end
	end

	assign out_valid = o_valid_q;
	assign out_data  = o_data_q;
	assign out_last  = o_last_q;

endmodule

// ===== hdl/snap_ring_node_receiver.sv =====
`timescale 1ns / 1ps
// ring node receiver: takes one transfer per cycle (a received byte or a lock release)
// while the four-entry job queue has room, and answers every input transfer with a
// run of 1 to 8 output transfers closed by tlast. a byte inside a packet gives one
// transfer, a foreign header gives four, an ack or nak reply six and a header error
// min(FLUSH_COUNT, 8) zero bytes, so the sustained rate is set by the back end, which
// drives one output transfer per cycle while m_axis_tready does not stall it. the output is
// registered, so the front keeps accepting while a result waits for m_axis_tready.
// device_address is written through cfg_we/cfg_wdata and must only change while idle.
module snap_ring_node_receiver #(
	parameter int PAYLOAD_MAX = snrr_pkg::PAYLOAD_MAX_DEF,
	parameter int FLUSH_COUNT = snrr_pkg::FLUSH_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [snrr_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
	input  logic                             s_axis_tuser,   // [0] opcode
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] tx_valid, [8:1] tx_byte, [9] payload_valid, [13:10] payload_index,
	// [21:14] payload_byte, [22] packet_ready, [30:23] reply_address,
	// [31] forwarding, [32] header_error, [39:33] zero
	output logic [snrr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic                             m_axis_tlast,
	// device address register
	input  logic                             cfg_we,
	input  logic [7:0]                       cfg_wdata
);

	logic           dev_addr_q;
	logic [7:0]     dev_addr_reg_q;
	logic           push;
	logic           queue_full;
	logic           queue_valid;
	logic           pop;
	snrr_pkg::job_t job_in;
	snrr_pkg::job_t job_head;

	// this node's ring address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_reg_q <= '0;
			dev_addr_q     <= 1'b0;
		end else if (cfg_we) begin
			dev_addr_reg_q <= cfg_wdata;
			dev_addr_q     <= 1'b1;
		end
	end

	// front: phase tracking, header checks, running crc, job classification
	snrr_front #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_byte    (s_axis_tdata),
		.dev_addr   (dev_addr_reg_q),
		.queue_full (queue_full),
		.push       (push),
		.job        (job_in)
	);

	// jobs wait here so either side can stall on its own
	snrr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (job_in),
		.full    (queue_full),
		.pop     (pop),
		.valid   (queue_valid),
		.rd_data (job_head)
	);

	// back: byte sequencing for forward, reply and flush runs
	snrr_back #(
		.FLUSH_COUNT (FLUSH_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_valid),
		.job_head  (job_head),
		.pop       (pop),
		.dev_addr  (dev_addr_q ? dev_addr_reg_q : 8'h00),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== hdl/snrr_checker.sv =====
`timescale 1ns / 1ps
`include "snap_ring_node_receiver_defines.svh"
// port-level checks on the result stream
module snrr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [snrr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);

	// a stalled result holds
	`SNRR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

	// a run continues in the very next cycle with the same status fields
	`SNRR_ASSERT_NEXT(a_run_status, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && $stable(m_axis_tdata[32:22]), "status changed inside a run")

	// a payload byte is a run of its own
	`SNRR_ASSERT_IMPL(a_payload_last, m_axis_tvalid && m_axis_tdata[9], m_axis_tlast && !m_axis_tdata[0], "payload transfer not alone")

	// a header error drops the lock and only ever sends zeros
	`SNRR_ASSERT_IMPL(a_flush_zero, m_axis_tvalid && m_axis_tdata[32], !m_axis_tdata[22] && !m_axis_tdata[31] && (m_axis_tdata[8:1] == 8'h00), "bad flush transfer")

endmodule

bind snap_ring_node_receiver snrr_checker u_snrr_checker (.*);

// ===== tb/sv/snap_ring_node_receiver_test.sv =====
`timescale 1ns / 1ps
module snap_ring_node_receiver_test;
	import snrr_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 6;
	localparam int PHASE_ITEMS    = 100;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT   = 100;
	localparam logic [7:0] CRC_POLY = 8'h8c;

	// sender gap and receiver stall, in percent, for each random phase
	localparam int GAP_PCT   [4] = '{0, 59, 0, 15};
	localparam int STALL_PCT [4] = '{0, 0, 59, 15};

	// one result transfer, unpacked from m_axis_tdata plus tlast
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic       payload_valid;
		logic [3:0] payload_index;
		logic [7:0] payload_byte;
		logic       packet_ready;
		logic [7:0] reply_address;
		logic       forwarding;
		logic       header_error;
	} ring_result_t;

	// one input transfer; crc_fill takes the running crc as the byte, typed_n > 0
	// replaces the predicted run by typed_n copies of typed
	typedef struct packed {
		opcode_t      op;
		logic [7:0]   data;
		logic         crc_fill;
		logic [3:0]   typed_n;
		ring_result_t typed;
	} rx_item_t;

	localparam ring_result_t NOTHING    = '0;
	localparam ring_result_t FLUSH_ZERO = '{tx_valid: 1'b1, header_error: 1'b1, default: '0};

	// directed part, run with device address 0
	localparam rx_item_t DIRECTED_ROWS [0:28] = '{
		// stray byte while idle, then sync, both only report status
		'{OP_BYTE, 8'h00, 1'b0, 4'd1, NOTHING},
		'{OP_BYTE, SYNC_BYTE, 1'b0, 4'd1, NOTHING},
		// bad hdb2: eight flush zeros with header_error
		'{OP_BYTE, 8'hff, 1'b0, 4'd8, FLUSH_ZERO},
		// one-byte packet for us asking for an ack, good crc sets the lock
		'{OP_BYTE, SYNC_BYTE, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h51, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h31, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h00, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h7a, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'hff, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h00, 1'b1, 4'd0, NOTHING},
		// release while idle
		'{OP_RELEASE, 8'h00, 1'b0, 4'd0, NOTHING},
		// zero-length payload goes straight to the crc check
		'{OP_BYTE, SYNC_BYTE, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h50, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h30, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h00, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h3c, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h00, 1'b1, 4'd0, NOTHING},
		// busy node: nak back to the incoming source
		'{OP_BYTE, SYNC_BYTE, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h53, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h30, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h00, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h11, 1'b0, 4'd0, NOTHING},
		// foreign zero-length packet, release in the middle of it
		'{OP_BYTE, SYNC_BYTE, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h51, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h30, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'hff, 1'b0, 4'd0, NOTHING},
		'{OP_RELEASE, 8'hff, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'h01, 1'b0, 4'd0, NOTHING},
		'{OP_BYTE, 8'ha5, 1'b0, 4'd0, NOTHING}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic        s_axis_tuser;   // [0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [0] tx_valid, [8:1] tx_byte, [9] payload_valid, [13:10] payload_index,
	// [21:14] payload_byte, [22] packet_ready, [30:23] reply_address,
	// [31] forwarding, [32] header_error, [39:33] zero
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	// idling knobs shared with the receiver process
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	bit          hold_go   = 1'b0;
	bit          hold_done = 1'b0;
	int          fail_count  = 0;
	int          quiet_cycles = 0;

	// predicted receiver state
	logic [7:0] node_addr = 8'h00;
	rx_phase_t  phase     = PH_IDLE;
	logic [7:0] hdb2_keep = 8'h00;
	logic [7:0] hdb1_keep = 8'h00;
	logic [4:0] len_left  = 5'd0;
	logic [7:0] src_keep  = 8'h00;
	logic [3:0] pay_idx   = 4'd0;
	logic [7:0] crc_run   = 8'h00;
	bit         want_ack  = 1'b0;
	bit         lock      = 1'b0;
	bit         passing   = 1'b0;
	bit         aborted   = 1'b0;
	logic [7:0] last_src  = 8'h00;

	ring_result_t step_out[$];      // results of the transfer being predicted
	ring_result_t results_due[$];   // results still to come out of the block
	rx_item_t     plan[$];          // input transfers waiting to be offered

	snap_ring_node_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	// maxim crc-8, bit-serial form of the reflected 0x8c polynomial
	function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// status fields are filled in once the whole run is known
	function automatic void emit(input bit txv, input logic [7:0] txb, input bit pv,
			input logic [3:0] pidx, input logic [7:0] pb);
		ring_result_t r;
		if (step_out.size() >= RESULT_LIMIT) begin
			return;
		end
		r = '0;
		r.tx_valid      = txv;
		r.tx_byte       = txv ? txb : 8'h00;
		r.payload_valid = pv;
		r.payload_index = pv ? pidx : 4'd0;
		r.payload_byte  = pv ? pb : 8'h00;
		step_out.push_back(r);
	endfunction

	function automatic void send_tx(input logic [7:0] b);
		emit(1'b1, b, 1'b0, 4'd0, 8'h00);
	endfunction

	// ack or nak packet; it restarts the running crc from zero over the reply header
	function automatic void send_reply(input logic [7:0] hdb2, input logic [7:0] dest);
		send_tx(SYNC_BYTE);
		crc_run = crc_step(8'h00, hdb2);
		send_tx(hdb2);
		crc_run = crc_step(crc_run, HDB1_REPLY);
		send_tx(HDB1_REPLY);
		crc_run = crc_step(crc_run, dest);
		send_tx(dest);
		crc_run = crc_step(crc_run, node_addr);
		send_tx(node_addr);
		send_tx(crc_run);
	endfunction

	// flush zeros unless a busy nak just went out, then drop everything
	function automatic void header_fault();
		if (!aborted) begin
			for (int k = 0; k < FLUSH_COUNT_DEF; k++) begin
				send_tx(8'h00);
			end
		end
		want_ack = 1'b0;
		lock     = 1'b0;
		passing  = 1'b0;
		phase    = PH_IDLE;
	endfunction

	// works out the result run of one accepted transfer and advances the state
	function automatic void compute_node_results(input opcode_t op, input logic [7:0] c,
			input bit book);
		bit herr;
		bit crc_good;
		herr = 1'b0;
		step_out.delete();
		if (op == OP_RELEASE) begin
			lock = 1'b0;
		end else begin
			case (phase)
				PH_IDLE: begin
					if (c == SYNC_BYTE) begin
						phase   = PH_SYNC;
						aborted = 1'b0;
					end
				end
				PH_SYNC: begin
					hdb2_keep = c;
					if (c[7:2] != HDB2_TAG) begin
						herr = 1'b1;
						header_fault();
					end else begin
						want_ack = (c[1:0] == ACK_REQUEST);
						crc_run  = crc_step(8'h00, c);
						phase    = PH_HDB2;
					end
				end
				PH_HDB2: begin
					hdb1_keep = c;
					if (c[7:4] != HDB1_TAG) begin
						herr = 1'b1;
						header_fault();
					end else begin
						if (int'(c[3:0]) > PAYLOAD_MAX_DEF) begin
							len_left = 5'(PAYLOAD_MAX_DEF);
						end else begin
							len_left = {1'b0, c[3:0]};
						end
						crc_run = crc_step(crc_run, c);
						phase   = PH_HDB1;
					end
				end
				PH_HDB1: begin
					if (c != node_addr) begin
						// someone else's packet: pass the header on as it came
						send_tx(SYNC_BYTE);
						send_tx(hdb2_keep);
						send_tx(hdb1_keep);
						send_tx(c);
						phase    = PH_DAB_PASS;
						want_ack = 1'b0;
						passing  = 1'b1;
					end else begin
						crc_run = crc_step(crc_run, c);
						phase   = PH_DAB;
					end
				end
				PH_DAB: begin
					if (lock) begin
						send_reply(HDB2_NAK, c);
						want_ack = 1'b0;
						aborted  = 1'b1;
						phase    = PH_IDLE;
					end else begin
						src_keep = c;
						pay_idx  = 4'd0;
						crc_run  = crc_step(crc_run, c);
						phase    = (len_left == 5'd0) ? PH_CRC : PH_DATA;
					end
				end
				PH_DATA: begin
					emit(1'b0, 8'h00, 1'b1, pay_idx, c);
					pay_idx = pay_idx + 4'd1;
					crc_run = crc_step(crc_run, c);
					if (len_left > 5'd0) begin
						len_left = len_left - 5'd1;
					end
					if (len_left == 5'd0) begin
						phase = PH_CRC;
					end
				end
				PH_CRC: begin
					crc_good = (c == crc_run);
					if (crc_good) begin
						lock     = 1'b1;
						last_src = src_keep;
					end
					if (want_ack) begin
						send_reply(crc_good ? HDB2_ACK : HDB2_NAK, src_keep);
						want_ack = 1'b0;
					end
					phase = PH_IDLE;
				end
				PH_DAB_PASS: begin
					send_tx(c);
					len_left = len_left + 5'd1;
					phase    = PH_DATA_PASS;
				end
				PH_DATA_PASS: begin
					send_tx(c);
					if (len_left > 5'd1) begin
						len_left = len_left - 5'd1;
					end else begin
						phase   = PH_IDLE;
						passing = 1'b0;
					end
				end
				default: begin
					herr = 1'b1;
					header_fault();
				end
			endcase
		end
		if (step_out.size() == 0) begin
			emit(1'b0, 8'h00, 1'b0, 4'd0, 8'h00);
		end
		foreach (step_out[k]) begin
			step_out[k].last          = (k == step_out.size() - 1);
			step_out[k].packet_ready  = lock;
			step_out[k].reply_address = last_src;
			step_out[k].forwarding    = passing;
			step_out[k].header_error  = herr;
			if (book) begin
				results_due.push_back(step_out[k]);
			end
		end
	endfunction

	function automatic void plan_item(input opcode_t op, input logic [7:0] data,
			input bit crc_fill);
		rx_item_t it;
		it          = '0;
		it.op       = op;
		it.data     = data;
		it.crc_fill = crc_fill;
		plan.push_back(it);
	endfunction

	// mostly well-formed packets with random content, some broken ones and noise
	function automatic void plan_packet();
		int unsigned pick;
		int unsigned len;
		bit          ours;
		logic [7:0]  hdb2;
		logic [7:0]  hdb1;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(3, 1)) plan_item(OP_BYTE, 8'($urandom), 1'b0);
			return;
		end
		if (pick < 12) begin
			plan_item(OP_RELEASE, 8'($urandom), 1'b0);
			return;
		end
		ours = ($urandom_range(99) < 55);
		hdb2 = {HDB2_TAG, 2'($urandom)};
		if ($urandom_range(99) < 6) begin
			hdb2 = 8'($urandom);
		end
		len  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4);
		hdb1 = {HDB1_TAG, 4'(len)};
		if ($urandom_range(99) < 6) begin
			hdb1 = 8'($urandom);
		end
		plan_item(OP_BYTE, SYNC_BYTE, 1'b0);
		plan_item(OP_BYTE, hdb2, 1'b0);
		plan_item(OP_BYTE, hdb1, 1'b0);
		plan_item(OP_BYTE, ours ? node_addr : 8'($urandom), 1'b0);
		if ($urandom_range(99) < 5) begin
			plan_item(OP_RELEASE, 8'($urandom), 1'b0);
		end
		plan_item(OP_BYTE, 8'($urandom), 1'b0);
		for (int k = 0; k < int'(hdb1[3:0]); k++) begin
			plan_item(OP_BYTE, 8'($urandom), 1'b0);
		end
		// our packets mostly carry the right crc so the lock gets set
		plan_item(OP_BYTE, 8'($urandom), ours && ($urandom_range(99) < 85));
		if ($urandom_range(99) < 20) begin
			plan_item(OP_RELEASE, 8'($urandom), 1'b0);
		end
	endfunction

	// offers every planned transfer, predicting each one as it is accepted
	task automatic drive_plan();
		rx_item_t   r;
		logic [7:0] b;
		while (plan.size() != 0) begin
			r = plan.pop_front();
			@(negedge clk);
			while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
			b = r.crc_fill ? crc_run : r.data;
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= b;
			s_axis_tuser  <= r.op;
			@(posedge clk);
			while (!s_axis_tready) begin
				@(posedge clk);
			end
			compute_node_results(r.op, b, r.typed_n == 0);
			for (int k = 0; k < int'(r.typed_n); k++) begin
				results_due.push_back(r.typed);
				results_due[$].last = (k == int'(r.typed_n) - 1);
			end
		end
	endtask

	// sender goes quiet until every expected result has come out
	task automatic settle(input int extra);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (extra) @(negedge clk);
	endtask

	task automatic set_node_address(input logic [7:0] v);
		settle(SETTLE_CYCLES);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		node_addr = v;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT) begin
				$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			end
		end
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// every result transfer against the oldest expectation
	always @(posedge clk) begin : check_results
		ring_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT) begin
					$display("%0t ns: no result expected, got tdata 0x%0h last %0b",
						$time, m_axis_tdata, m_axis_tlast);
				end
			end else begin
				want = results_due.pop_front();
				check_field("tx_valid", want.tx_valid, m_axis_tdata[0]);
				check_field("tx_byte", want.tx_byte, m_axis_tdata[8:1]);
				check_field("last", want.last, m_axis_tlast);
				check_field("payload_valid", want.payload_valid, m_axis_tdata[9]);
				check_field("payload_index", want.payload_index, m_axis_tdata[13:10]);
				check_field("payload_byte", want.payload_byte, m_axis_tdata[21:14]);
				check_field("packet_ready", want.packet_ready, m_axis_tdata[22]);
				check_field("reply_address", want.reply_address, m_axis_tdata[30:23]);
				check_field("forwarding", want.forwarding, m_axis_tdata[31]);
				check_field("header_error", want.header_error, m_axis_tdata[32]);
				check_field("padding", 0, m_axis_tdata[39:33]);
			end
		end
	end

	// ends the run when no transfer has moved for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		bit          paused;
		logic [7:0]  addr;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 8'h00;
		paused        = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed part at address zero, no idling
		set_node_address(8'h00);
		foreach (DIRECTED_ROWS[i]) begin
			plan.push_back(DIRECTED_ROWS[i]);
		end
		drive_plan();

		// random phases, each with its own address and idling pattern
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: addr = 8'hff;
				1: addr = 8'($urandom);
				2: addr = 8'h00;
				default: addr = 8'($urandom_range(254, 1));
			endcase
			set_node_address(addr);
			gap_pct   = GAP_PCT[p];
			stall_pct = STALL_PCT[p];
			sent      = 0;
			while (sent < PHASE_ITEMS) begin
				// last phase: a long receiver hold-off while we keep offering,
				// later a full drain in the middle of the stream
				if (p == 3 && sent >= 30 && !hold_go) begin
					hold_go = 1'b1;
				end
				if (p == 3 && sent >= 70 && !paused) begin
					settle(0);
					paused = 1'b1;
				end
				plan_packet();
				sent += plan.size();
				drive_plan();
			end
		end

		settle(SETTLE_CYCLES);
		if (fail_count == 0 && results_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/snrr_pkg.sv
hdl/snrr_front.sv
hdl/snrr_fifo.sv
hdl/snrr_back.sv
hdl/snap_ring_node_receiver.sv
hdl/snrr_checker.sv
tb/sv/snap_ring_node_receiver_test.sv
